FILE: hw/rtl/rgb_to_hsv_converter_macros.svh
// Assertion macros shared by the converter's checker.
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// Same-cycle implication, masked during reset.
`define RHC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rgb_to_hsv_converter: assertion failed");

// Next-cycle implication, masked during reset.
`define RHC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rgb_to_hsv_converter: assertion failed");

// Next-cycle implication that also runs while reset is asserted.
`define RHC_ASSERT_RAW(name, ante, cons) \
    name: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("rgb_to_hsv_converter: assertion failed");

`endif

FILE: hw/rtl/rgbhsv_pkg.sv
// Shared types and constants of the RGB to HSV converter.
`timescale 1ns / 1ps

package rgbhsv_pkg;

    localparam int CHANNEL_BITS_DEF      = 8;
    localparam int HUE_FRACTION_BITS_DEF = 6;

    localparam int HUE_W    = 15;
    localparam int SAT_W    = 8;
    localparam int BRIGHT_W = 8;

    // Hue sector width and full circle in whole degrees.
    localparam int HUE_SIXTH_DEG  = 60;
    localparam int HUE_CIRCLE_DEG = 360;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sect_t;

    typedef struct packed {
        sect_t sector;
        logic  neg;
        logic  gray;
    } hsv_tag_t;

endpackage

FILE: hw/rtl/rgbhsv_front.sv
// Input stage: max, min, delta, hue sector and signed channel difference.
`timescale 1ns / 1ps

module rgbhsv_front #(
    parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  logic [CHANNEL_BITS-1:0]    up_red,
    input  logic [CHANNEL_BITS-1:0]    up_green,
    input  logic [CHANNEL_BITS-1:0]    up_blue,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output rgbhsv_pkg::hsv_tag_t       dn_tag,
    output logic [CHANNEL_BITS-1:0]    dn_bright,
    output logic [CHANNEL_BITS-1:0]    dn_delta,
    output logic [CHANNEL_BITS-1:0]    dn_mag
);
    import rgbhsv_pkg::*;

    logic                    valid_reg;
    hsv_tag_t                tag_reg, tag_next;
    logic [CHANNEL_BITS-1:0] bright_reg, bright_next;
    logic [CHANNEL_BITS-1:0] delta_reg, delta_next;
    logic [CHANNEL_BITS-1:0] mag_reg, mag_next;

    logic [CHANNEL_BITS-1:0] lo;
    logic [CHANNEL_BITS-1:0] op_a, op_b;
    logic [CHANNEL_BITS:0]   diff;

    assign up_ready = !valid_reg || dn_ready;

    always_comb begin
        // Red wins ties over green, green over blue.
        if (up_red >= up_green && up_red >= up_blue) begin
            tag_next.sector = SECT_RED;
            bright_next     = up_red;
        end else if (up_green >= up_blue) begin
            tag_next.sector = SECT_GREEN;
            bright_next     = up_green;
        end else begin
            tag_next.sector = SECT_BLUE;
            bright_next     = up_blue;
        end

        lo = (up_red < up_green) ? up_red : up_green;
        lo = (lo < up_blue) ? lo : up_blue;
        delta_next    = bright_next - lo;
        tag_next.gray = (delta_next == '0);

        case (tag_next.sector)
            SECT_RED: begin
                op_a = up_green;
                op_b = up_blue;
            end
            SECT_GREEN: begin
                op_a = up_blue;
                op_b = up_red;
            end
            SECT_BLUE: begin
                op_a = up_red;
                op_b = up_green;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase

        diff         = {1'b0, op_a} - {1'b0, op_b};
        tag_next.neg = diff[CHANNEL_BITS];
        mag_next     = tag_next.neg ? CHANNEL_BITS'(-diff) : diff[CHANNEL_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && up_ready) begin
            tag_reg    <= tag_next;
            bright_reg <= bright_next;
            delta_reg  <= delta_next;
            mag_reg    <= mag_next;
        end
    end

    assign dn_valid  = valid_reg;
    assign dn_tag    = tag_reg;
    assign dn_bright = bright_reg;
    assign dn_delta  = delta_reg;
    assign dn_mag    = mag_reg;

endmodule

FILE: hw/rtl/rgbhsv_cell.sv
// One cell of the divider chain: a restoring step for saturation and for hue.
`timescale 1ns / 1ps

module rgbhsv_cell #(
    parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF,
    parameter int STEPS        = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  rgbhsv_pkg::hsv_tag_t       up_tag,
    input  logic [CHANNEL_BITS-1:0]    up_bright,
    input  logic [CHANNEL_BITS-1:0]    up_delta,
    input  logic [CHANNEL_BITS-1:0]    up_s_rem,
    input  logic [STEPS-1:0]           up_s_nq,
    input  logic [CHANNEL_BITS-1:0]    up_h_rem,
    input  logic [STEPS-1:0]           up_h_nq,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output rgbhsv_pkg::hsv_tag_t       dn_tag,
    output logic [CHANNEL_BITS-1:0]    dn_bright,
    output logic [CHANNEL_BITS-1:0]    dn_delta,
    output logic [CHANNEL_BITS-1:0]    dn_s_rem,
    output logic [STEPS-1:0]           dn_s_nq,
    output logic [CHANNEL_BITS-1:0]    dn_h_rem,
    output logic [STEPS-1:0]           dn_h_nq
);
    import rgbhsv_pkg::*;

    logic                    valid_reg;
    hsv_tag_t                tag_reg;
    logic [CHANNEL_BITS-1:0] bright_reg, delta_reg;
    logic [CHANNEL_BITS-1:0] s_rem_reg, s_rem_next;
    logic [STEPS-1:0]        s_nq_reg, s_nq_next;
    logic [CHANNEL_BITS-1:0] h_rem_reg, h_rem_next;
    logic [STEPS-1:0]        h_nq_reg, h_nq_next;

    logic [CHANNEL_BITS:0] s_trial, s_diff, h_trial, h_diff;
    logic                  s_ge, h_ge;

    assign up_ready = !valid_reg || dn_ready;

    // Numerator bits leave the top of nq while quotient bits enter at the bottom.
    always_comb begin
        s_trial    = {up_s_rem, up_s_nq[STEPS-1]};
        s_diff     = s_trial - {1'b0, up_bright};
        s_ge       = !s_diff[CHANNEL_BITS] || s_trial[CHANNEL_BITS];
        s_rem_next = s_ge ? s_diff[CHANNEL_BITS-1:0] : s_trial[CHANNEL_BITS-1:0];
        s_nq_next  = {up_s_nq[STEPS-2:0], s_ge};

        h_trial    = {up_h_rem, up_h_nq[STEPS-1]};
        h_diff     = h_trial - {1'b0, up_delta};
        h_ge       = !h_diff[CHANNEL_BITS] || h_trial[CHANNEL_BITS];
        h_rem_next = h_ge ? h_diff[CHANNEL_BITS-1:0] : h_trial[CHANNEL_BITS-1:0];
        h_nq_next  = {up_h_nq[STEPS-2:0], h_ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && up_ready) begin
            tag_reg    <= up_tag;
            bright_reg <= up_bright;
            delta_reg  <= up_delta;
            s_rem_reg  <= s_rem_next;
            s_nq_reg   <= s_nq_next;
            h_rem_reg  <= h_rem_next;
            h_nq_reg   <= h_nq_next;
        end
    end

    assign dn_valid  = valid_reg;
    assign dn_tag    = tag_reg;
    assign dn_bright = bright_reg;
    assign dn_delta  = delta_reg;
    assign dn_s_rem  = s_rem_reg;
    assign dn_s_nq   = s_nq_reg;
    assign dn_h_rem  = h_rem_reg;
    assign dn_h_nq   = h_nq_reg;

endmodule

FILE: hw/rtl/rgbhsv_back.sv
// Output stage: hue from sector and quotient, gray override, result register.
`timescale 1ns / 1ps

module rgbhsv_back #(
    parameter int CHANNEL_BITS      = rgbhsv_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = rgbhsv_pkg::HUE_FRACTION_BITS_DEF,
    parameter int STEPS             = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  rgbhsv_pkg::hsv_tag_t          up_tag,
    input  logic [CHANNEL_BITS-1:0]       up_bright,
    input  logic [STEPS-1:0]              up_s_q,
    input  logic [STEPS-1:0]              up_h_q,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rgbhsv_pkg::HUE_W-1:0]  m_hue,
    output logic [rgbhsv_pkg::SAT_W-1:0]  m_saturation,
    output logic [rgbhsv_pkg::BRIGHT_W-1:0] m_brightness
);
    import rgbhsv_pkg::*;

    localparam int HW = $clog2(HUE_CIRCLE_DEG << HUE_FRACTION_BITS);
    localparam int HX = (HW > HUE_W) ? HW : HUE_W;
    localparam int SX = (STEPS > SAT_W) ? STEPS : SAT_W;
    localparam int BX = (CHANNEL_BITS > BRIGHT_W) ? CHANNEL_BITS : BRIGHT_W;

    localparam logic [HX-1:0] HUE_CIRCLE = HX'(HUE_CIRCLE_DEG << HUE_FRACTION_BITS);
    localparam logic [HX-1:0] HUE_BASE_G = HX'((2 * HUE_SIXTH_DEG) << HUE_FRACTION_BITS);
    localparam logic [HX-1:0] HUE_BASE_B = HX'((4 * HUE_SIXTH_DEG) << HUE_FRACTION_BITS);

    logic                  valid_reg;
    logic [HUE_W-1:0]      hue_reg, hue_next;
    logic [SAT_W-1:0]      sat_reg, sat_next;
    logic [BRIGHT_W-1:0]   bright_reg, bright_next;

    logic [HX-1:0] q_x, base, hue_x;
    logic [SX-1:0] sat_x;
    logic [BX-1:0] bright_x;

    assign up_ready = !valid_reg || m_ready;

    always_comb begin
        q_x = HX'(up_h_q);
        case (up_tag.sector)
            SECT_RED:   base = '0;
            SECT_GREEN: base = HUE_BASE_G;
            SECT_BLUE:  base = HUE_BASE_B;
            default:    base = '0;
        endcase

        // A negative red-sector hue wraps around the full circle.
        if (up_tag.neg && up_tag.sector == SECT_RED && q_x != '0) begin
            hue_x = HUE_CIRCLE - q_x;
        end else if (up_tag.neg) begin
            hue_x = base - q_x;
        end else begin
            hue_x = base + q_x;
        end

        sat_x    = SX'(up_s_q);
        bright_x = BX'(up_bright);

        hue_next    = up_tag.gray ? '0 : hue_x[HUE_W-1:0];
        sat_next    = up_tag.gray ? '0 : sat_x[SAT_W-1:0];
        bright_next = bright_x[BRIGHT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && up_ready) begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= bright_next;
        end
    end

    assign m_valid      = valid_reg;
    assign m_hue        = hue_reg;
    assign m_saturation = sat_reg;
    assign m_brightness = bright_reg;

endmodule

FILE: hw/rtl/rgb_to_hsv_converter.sv
// RGB to HSV converter: takes one pixel word per clock while the output is not
// stalled and returns hue in 1/2^HUE_FRACTION_BITS degree, saturation scaled to
// full channel range and brightness (the largest channel). STEPS is the larger
// of CHANNEL_BITS and the hue quotient width (6 + HUE_FRACTION_BITS). The pipeline
// is one input stage, a chain of STEPS divider cells that each resolve one
// quotient bit of both divisions, and one output register. Every stage holds its
// word while the next one is stalled, so a stalled output fills the chain before
// input is refused.
`timescale 1ns / 1ps

module rgb_to_hsv_converter #(
    parameter int CHANNEL_BITS      = rgbhsv_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = rgbhsv_pkg::HUE_FRACTION_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [CHANNEL_BITS-1:0]         s_red,
    input  logic [CHANNEL_BITS-1:0]         s_green,
    input  logic [CHANNEL_BITS-1:0]         s_blue,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rgbhsv_pkg::HUE_W-1:0]    m_hue,
    output logic [rgbhsv_pkg::SAT_W-1:0]    m_saturation,
    output logic [rgbhsv_pkg::BRIGHT_W-1:0] m_brightness
);
    import rgbhsv_pkg::*;

    localparam int HUE_SIXTH = HUE_SIXTH_DEG << HUE_FRACTION_BITS;
    localparam int HQ        = $clog2(HUE_SIXTH + 1);
    localparam int STEPS     = (CHANNEL_BITS > HQ) ? CHANNEL_BITS : HQ;
    localparam int NW        = CHANNEL_BITS + STEPS;

    logic                    f_valid, f_ready;
    hsv_tag_t                f_tag;
    logic [CHANNEL_BITS-1:0] f_bright, f_delta, f_mag;
    logic [NW-1:0]           sat_num, hue_num;

    logic                    c_valid [0:STEPS];
    logic                    c_ready [0:STEPS];
    hsv_tag_t                c_tag   [0:STEPS];
    logic [CHANNEL_BITS-1:0] c_bright[0:STEPS];
    logic [CHANNEL_BITS-1:0] c_delta [0:STEPS];
    logic [CHANNEL_BITS-1:0] c_s_rem [0:STEPS];
    logic [STEPS-1:0]        c_s_nq  [0:STEPS];
    logic [CHANNEL_BITS-1:0] c_h_rem [0:STEPS];
    logic [STEPS-1:0]        c_h_nq  [0:STEPS];

    rgbhsv_front #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (s_valid),
        .up_ready (s_ready),
        .up_red   (s_red),
        .up_green (s_green),
        .up_blue  (s_blue),
        .dn_valid (f_valid),
        .dn_ready (f_ready),
        .dn_tag   (f_tag),
        .dn_bright(f_bright),
        .dn_delta (f_delta),
        .dn_mag   (f_mag)
    );

    // Saturation divides full*delta by max; hue divides |diff|*sixth by delta.
    assign sat_num = (NW'(f_delta) << CHANNEL_BITS) - NW'(f_delta);
    assign hue_num = NW'(f_mag) * NW'(HUE_SIXTH);

    assign c_valid[0]  = f_valid;
    assign f_ready     = c_ready[0];
    assign c_tag[0]    = f_tag;
    assign c_bright[0] = f_bright;
    assign c_delta[0]  = f_delta;
    assign c_s_rem[0]  = sat_num[NW-1:STEPS];
    assign c_s_nq[0]   = sat_num[STEPS-1:0];
    assign c_h_rem[0]  = hue_num[NW-1:STEPS];
    assign c_h_nq[0]   = hue_num[STEPS-1:0];

    for (genvar i = 0; i < STEPS; i++) begin : g_cell
        rgbhsv_cell #(
            .CHANNEL_BITS(CHANNEL_BITS),
            .STEPS       (STEPS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .up_valid (c_valid[i]),
            .up_ready (c_ready[i]),
            .up_tag   (c_tag[i]),
            .up_bright(c_bright[i]),
            .up_delta (c_delta[i]),
            .up_s_rem (c_s_rem[i]),
            .up_s_nq  (c_s_nq[i]),
            .up_h_rem (c_h_rem[i]),
            .up_h_nq  (c_h_nq[i]),
            .dn_valid (c_valid[i+1]),
            .dn_ready (c_ready[i+1]),
            .dn_tag   (c_tag[i+1]),
            .dn_bright(c_bright[i+1]),
            .dn_delta (c_delta[i+1]),
            .dn_s_rem (c_s_rem[i+1]),
            .dn_s_nq  (c_s_nq[i+1]),
            .dn_h_rem (c_h_rem[i+1]),
            .dn_h_nq  (c_h_nq[i+1])
        );
    end

    rgbhsv_back #(
        .CHANNEL_BITS     (CHANNEL_BITS),
        .HUE_FRACTION_BITS(HUE_FRACTION_BITS),
        .STEPS            (STEPS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .up_valid    (c_valid[STEPS]),
        .up_ready    (c_ready[STEPS]),
        .up_tag      (c_tag[STEPS]),
        .up_bright   (c_bright[STEPS]),
        .up_s_q      (c_s_nq[STEPS]),
        .up_h_q      (c_h_nq[STEPS]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hue       (m_hue),
        .m_saturation(m_saturation),
        .m_brightness(m_brightness)
    );

endmodule

FILE: hw/rtl/rgb_to_hsv_converter_checker.sv
// Port-level checker for the RGB to HSV converter, bound to the top level.
`timescale 1ns / 1ps
`include "rgb_to_hsv_converter_macros.svh"

module rgb_to_hsv_converter_checker #(
    parameter int CHANNEL_BITS      = rgbhsv_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = rgbhsv_pkg::HUE_FRACTION_BITS_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [rgbhsv_pkg::HUE_W-1:0]    m_hue,
    input logic [rgbhsv_pkg::SAT_W-1:0]    m_saturation,
    input logic [rgbhsv_pkg::BRIGHT_W-1:0] m_brightness
);
    import rgbhsv_pkg::*;

    localparam int  HUE_CIRCLE = HUE_CIRCLE_DEG << HUE_FRACTION_BITS;
    localparam bit  SAT_EXACT  = (CHANNEL_BITS <= SAT_W);
    localparam bit  HUE_FITS   = (HUE_CIRCLE < (1 << HUE_W));

    // Hold a stalled result word.
    `RHC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable({m_hue, m_saturation, m_brightness}))

    // Drop all results on reset.
    `RHC_ASSERT_RAW(a_reset_empty, !aresetn, !m_valid)

    // Zero saturation only comes from a gray pixel, whose hue is zero.
    `RHC_ASSERT_NOW(a_gray_hue, SAT_EXACT && m_valid && m_saturation == '0, m_hue == '0)

    // Hue stays below the full circle.
    `RHC_ASSERT_NOW(a_hue_range, HUE_FITS && m_valid, m_hue < HUE_W'(HUE_CIRCLE))

endmodule

bind rgb_to_hsv_converter rgb_to_hsv_converter_checker #(
    .CHANNEL_BITS     (CHANNEL_BITS),
    .HUE_FRACTION_BITS(HUE_FRACTION_BITS)
) u_checker (.*);
